>>> rtl/gyz_pkg.sv
// Shared types and constants for the gyro yaw integrator with still-time bias trim.
// Used by the controller, the datapath, the top level and the checker.
package gyz_pkg;

	// Field widths of the channels and registers.
	localparam int RATE_W     = 24;
	localparam int COUNT_W    = 16;
	localparam int TIME_W     = 63;
	localparam int YAW_W      = 64;
	localparam int SUM_W      = 40;
	localparam int STEP_W     = 20;
	localparam int LIMIT_W    = 23;
	localparam int WINDOW_W   = 32;
	localparam int GAIN_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Derived datapath widths.
	localparam int PAIR_W      = RATE_W + 1;
	localparam int PROD_W      = PAIR_W + STEP_W + 1;
	localparam int HALF_W      = SUM_W / 2;
	localparam int PP_W        = GAIN_W + HALF_W;
	localparam int TPROD_W     = GAIN_W + SUM_W;
	localparam int TRIM_SHIFT  = 16;
	localparam int QUO_W       = TPROD_W - TRIM_SHIFT;
	localparam int BSUM_W      = QUO_W + 2;
	localparam int DIV_CNT_W   = $clog2(QUO_W);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STILL_LIM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIM_WIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIM_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_BIAS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_CALIB = 3'd5;

	// Register reset values.
	localparam logic [STEP_W-1:0]   MAX_STEP_RST  = 20'd25000;
	localparam logic [LIMIT_W-1:0]  STILL_LIM_RST = 23'd20972;
	localparam logic [WINDOW_W-1:0] TRIM_WIN_RST  = 32'd1000000;
	localparam logic [GAIN_W-1:0]   TRIM_GAIN_RST = 17'd6554;

	typedef struct packed {
		logic signed [RATE_W-1:0] gyro_rate_raw;
		logic [TIME_W-1:0]        sample_time_us;
		logic                     motors_idle;
	} gyz_in_t;

	typedef struct packed {
		logic signed [YAW_W-1:0]  yaw_total;
		logic signed [RATE_W-1:0] corrected_rate;
		logic signed [RATE_W-1:0] bias_now;
		logic                     is_calibrated;
		logic                     bias_trimmed;
	} gyz_out_t;

	// Strobes from the controller to the datapath, one per step.
	typedef struct packed {
		logic load_in;
		logic diff;
		logic step;
		logic mul;
		logic acc;
		logic mlo;
		logic mhi;
		logic div_step;
		logic bias_upd;
		logic load_out;
	} gyz_cmd_t;

	typedef struct packed {
		logic trim_end;
	} gyz_stat_t;

endpackage

>>> rtl/gyro_yaw_integrator_zupt_top.sv
// Top level of the gyro yaw integrator with still-time bias trim.
// Depends on gyz_pkg; instantiates gyz_ctrl and gyz_dpath.
//
// Usage:
// Each input item carries one raw gyro Z rate, its timestamp in microseconds and
// a motors-idle flag. Each item gives exactly one result item: the saturating yaw
// sum of (rate + previous rate) times the clamped time step, the bias-corrected
// rate, the current bias, the calibrated flag and a flag that tells whether this
// item closed an averaging window and trimmed the bias.
// An item is accepted when in_valid is high and in_stall is low; a result is taken
// when out_valid is high and out_stall is low.
// An ordinary item goes through the difference, step, multiply and accumulate states
// before its result is written to the output register. An item that ends a window adds
// two partial products of the trim gain times the residual sum, a one-bit-per-cycle
// divide of 41 steps by the sample count, and the bias update. The block takes no new
// item until the previous one is written; the sequencer works on one item at a time.
// Results sit in an output register, so a new item is accepted while an earlier
// result still waits; if the receiver keeps stalling, the next finished item
// waits inside the block and in_stall stays high until the register frees.
// Reset clears the state, loads the register defaults, a bias of zero and an
// uncalibrated flag. Writing initial_bias or initial_calibrated loads the bias or flag at
// once. The user must write configuration only while idle; the block does not enforce it.
module gyro_yaw_integrator_zupt_top import gyz_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  gyz_in_t               in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output gyz_out_t              out_item
);

	gyz_cmd_t  cmd;
	gyz_stat_t status;

	// The controller steps through the item; the datapath holds all arithmetic.
	gyz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gyz_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_item      (in_item),
		.cmd          (cmd),
		.status       (status),
		.out_item     (out_item)
	);

endmodule

>>> rtl/gyz_ctrl.sv
// Sequencing controller of the gyro yaw integrator.
// Depends on gyz_pkg for the command and status types.
module gyz_ctrl import gyz_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  gyz_stat_t status,
	output gyz_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIFF  = 4'd1;
	localparam logic [3:0] ST_STEP  = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_MLO   = 4'd5;
	localparam logic [3:0] ST_MHI   = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_BIAS  = 4'd8;
	localparam logic [3:0] ST_WRITE = 4'd9;

	logic [3:0]           state_q;
	logic [3:0]           state_nx;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nx    = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_nx = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_nx = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc  = 1'b1;
				state_nx = status.trim_end ? ST_MLO : ST_WRITE;
			end
			ST_MLO: begin
				cmd.mlo  = 1'b1;
				state_nx = ST_MHI;
			end
			ST_MHI: begin
				cmd.mhi  = 1'b1;
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_nx = ST_BIAS;
				end
			end
			ST_BIAS: begin
				cmd.bias_upd = 1'b1;
				state_nx     = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.mhi) begin
				cnt_q <= DIV_CNT_W'(QUO_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/gyz_dpath.sv
// Datapath of the gyro yaw integrator: registers, integration, residual window and
// the serial trim multiply and divide. Depends on gyz_pkg; driven by gyz_ctrl.
module gyz_dpath import gyz_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  gyz_in_t               in_item,
	input  gyz_cmd_t              cmd,
	output gyz_stat_t             status,
	output gyz_out_t              out_item
);

	localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [YAW_W-1:0]  YAW_MAX  = {1'b0, {(YAW_W-1){1'b1}}};
	localparam logic [YAW_W-1:0]  YAW_MIN  = {1'b1, {(YAW_W-1){1'b0}}};

	// Configuration.
	logic [STEP_W-1:0]   max_step_q;
	logic [LIMIT_W-1:0]  still_lim_q;
	logic [WINDOW_W-1:0] trim_win_q;
	logic [GAIN_W-1:0]   trim_gain_q;

	// Architectural state.
	logic [RATE_W-1:0]  bias_q;
	logic               calib_q;
	logic [RATE_W-1:0]  prev_q;
	logic [YAW_W-1:0]   yaw_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  win_q;
	logic [TIME_W-1:0]  last_q;
	logic               have_q;

	// Per-item working registers.
	logic [RATE_W-1:0]        raw_q;
	logic [TIME_W-1:0]        now_q;
	logic                     idle_q;
	logic [TIME_W:0]          diff_q;
	logic                     first_q;
	logic [RATE_W-1:0]        rate_q;
	logic [STEP_W-1:0]        dt_q;
	logic signed [PAIR_W-1:0] pair_q;
	logic                     still_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [TIME_W:0]          wdiff_q;
	logic                     trimmed_q;
	logic [SUM_W-1:0]         smag_q;
	logic                     neg_q;
	logic [COUNT_W-1:0]       divisor_q;
	logic [TPROD_W-1:0]       pp_q;
	logic [QUO_W-1:0]         quo_q;
	logic [COUNT_W-1:0]       rem_q;

	// Combinational terms.
	logic [TIME_W:0]          diff_full;
	logic [RATE_W:0]          rdiff;
	logic [RATE_W-1:0]        rate_sat;
	logic [RATE_W-1:0]        mag;
	logic                     still;
	logic [SUM_W:0]           sum_full;
	logic [SUM_W-1:0]         sum_sat;
	logic [STEP_W-1:0]        dt_sel;
	logic signed [PROD_W-1:0] prod;
	logic [YAW_W:0]           ysum;
	logic [YAW_W-1:0]         yaw_sat;
	logic                     trim_end;
	logic [PP_W-1:0]          pp_lo;
	logic [PP_W-1:0]          pp_hi;
	logic [TPROD_W-1:0]       pp_full;
	logic [COUNT_W:0]         rem_sh;
	logic [COUNT_W:0]         rem_sub;
	logic                     rem_ge;
	logic [BSUM_W-1:0]        quo_ext;
	logic [BSUM_W-1:0]        bsum;
	logic [RATE_W-1:0]        bias_sat;

	assign diff_full = {1'b0, now_q} - {1'b0, last_q};

	assign rdiff    = {raw_q[RATE_W-1], raw_q} - {bias_q[RATE_W-1], bias_q};
	assign rate_sat = (rdiff[RATE_W] != rdiff[RATE_W-1]) ?
		(rdiff[RATE_W] ? RATE_MIN : RATE_MAX) : rdiff[RATE_W-1:0];

	// The magnitude of the most negative rate still fits as an unsigned value.
	assign mag   = rate_q[RATE_W-1] ? (~rate_q + 1'b1) : rate_q;
	assign still = idle_q && (mag < {1'b0, still_lim_q});

	assign sum_full = {sum_q[SUM_W-1], sum_q}
		+ {{(SUM_W+1-RATE_W){rate_q[RATE_W-1]}}, rate_q};
	assign sum_sat  = (sum_full[SUM_W] != sum_full[SUM_W-1]) ?
		(sum_full[SUM_W] ? SUM_MIN : SUM_MAX) : sum_full[SUM_W-1:0];

	assign dt_sel = (first_q || diff_q[TIME_W]) ? '0 :
		((diff_q[TIME_W-1:0] > {{(TIME_W-STEP_W){1'b0}}, max_step_q}) ?
		max_step_q : diff_q[STEP_W-1:0]);

	assign prod = pair_q * $signed({1'b0, dt_q});

	assign ysum    = {yaw_q[YAW_W-1], yaw_q} + {{(YAW_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign yaw_sat = (ysum[YAW_W] != ysum[YAW_W-1]) ?
		(ysum[YAW_W] ? YAW_MIN : YAW_MAX) : ysum[YAW_W-1:0];

	// A window whose start lies after the current time has not ended.
	assign trim_end = still_q && !wdiff_q[TIME_W] &&
		(wdiff_q[TIME_W-1:0] >= {{(TIME_W-WINDOW_W){1'b0}}, trim_win_q});
	assign status.trim_end = trim_end;

	assign pp_lo   = trim_gain_q * smag_q[HALF_W-1:0];
	assign pp_hi   = trim_gain_q * smag_q[SUM_W-1:HALF_W];
	assign pp_full = pp_q + {pp_hi, {HALF_W{1'b0}}};

	assign rem_sh  = {rem_q, quo_q[QUO_W-1]};
	assign rem_ge  = (rem_sh >= {1'b0, divisor_q});
	assign rem_sub = rem_sh - {1'b0, divisor_q};

	assign quo_ext  = {2'b00, quo_q};
	assign bsum     = {{(BSUM_W-RATE_W){bias_q[RATE_W-1]}}, bias_q}
		+ (neg_q ? (~quo_ext + 1'b1) : quo_ext);
	assign bias_sat = ($signed(bsum) > $signed({{(BSUM_W-RATE_W){1'b0}}, RATE_MAX})) ? RATE_MAX :
		(($signed(bsum) < $signed({{(BSUM_W-RATE_W){1'b1}}, RATE_MIN})) ? RATE_MIN :
		bsum[RATE_W-1:0]);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q  <= MAX_STEP_RST;
			still_lim_q <= STILL_LIM_RST;
			trim_win_q  <= TRIM_WIN_RST;
			trim_gain_q <= TRIM_GAIN_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_MAX_STEP:  max_step_q  <= cfg_data[STEP_W-1:0];
				CFG_STILL_LIM: still_lim_q <= cfg_data[LIMIT_W-1:0];
				CFG_TRIM_WIN:  trim_win_q  <= cfg_data[WINDOW_W-1:0];
				CFG_TRIM_GAIN: trim_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Bias and calibrated flag: loaded by software or by a trim.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q  <= '0;
			calib_q <= 1'b0;
		end else begin
			if (cfg_write_en && (cfg_index == CFG_INIT_BIAS)) begin
				bias_q <= cfg_data[RATE_W-1:0];
			end else if (cmd.bias_upd) begin
				bias_q <= bias_sat;
			end
			if (cfg_write_en && (cfg_index == CFG_INIT_CALIB)) begin
				calib_q <= cfg_data[0];
			end else if (cmd.bias_upd) begin
				calib_q <= 1'b1;
			end
		end
	end

	// Integration and residual window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			yaw_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
			win_q   <= '0;
			last_q  <= '0;
			have_q  <= 1'b0;
		end else begin
			if (cmd.diff) begin
				last_q <= now_q;
				have_q <= 1'b1;
			end
			if (cmd.step) begin
				prev_q <= rate_q;
				if (still) begin
					if (count_q == '0) begin
						win_q <= now_q;
					end
					if (count_q != '1) begin
						sum_q   <= sum_sat;
						count_q <= count_q + 1'b1;
					end
				end else begin
					sum_q   <= '0;
					count_q <= '0;
				end
			end
			if (cmd.acc) begin
				yaw_q <= yaw_sat;
				if (trim_end) begin
					sum_q   <= '0;
					count_q <= '0;
				end
			end
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q  <= in_item.gyro_rate_raw;
			now_q  <= in_item.sample_time_us;
			idle_q <= in_item.motors_idle;
		end
		if (cmd.diff) begin
			diff_q  <= diff_full;
			first_q <= !have_q;
			rate_q  <= rate_sat;
		end
		if (cmd.step) begin
			dt_q    <= dt_sel;
			pair_q  <= $signed({rate_q[RATE_W-1], rate_q}) + $signed({prev_q[RATE_W-1], prev_q});
			still_q <= still;
		end
		if (cmd.mul) begin
			prod_q  <= prod;
			wdiff_q <= {1'b0, now_q} - {1'b0, win_q};
		end
		if (cmd.acc) begin
			trimmed_q <= trim_end;
			smag_q    <= sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
			neg_q     <= sum_q[SUM_W-1];
			divisor_q <= count_q;
		end
		if (cmd.mlo) begin
			pp_q <= {{(TPROD_W-PP_W){1'b0}}, pp_lo};
		end
		if (cmd.mhi) begin
			quo_q <= pp_full[TPROD_W-1:TRIM_SHIFT];
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
		end
		if (cmd.load_out) begin
			out_item.yaw_total      <= yaw_q;
			out_item.corrected_rate <= rate_q;
			out_item.bias_now       <= bias_q;
			out_item.is_calibrated  <= calib_q;
			out_item.bias_trimmed   <= trimmed_q;
		end
	end

endmodule

>>> rtl/gyz_checker.sv
// Port-level checks for the gyro yaw integrator, attached to the top by bind.
// Depends on gyz_pkg for the item types.
module gyz_checker import gyz_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input gyz_out_t              out_item
);

	// An accepted item keeps the block busy through its four compute steps.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken while an item is still in work");

	// A new result only appears after the block was working on an item.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// A trim always leaves the block calibrated.
	a_trim_calibrates: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.bias_trimmed) |-> out_item.is_calibrated)
		else $error("trimmed result not marked calibrated");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled result changed");

endmodule

bind gyro_yaw_integrator_zupt_top gyz_checker u_gyz_checker (.*);
